### rtl/lcdseq_pkg.sv
package lcdseq_pkg;

    // field widths
    localparam int FUNC_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int COL_W    = 6;
    localparam int NUM_W    = 16;
    localparam int NIB_W    = 4;
    localparam int WAIT_W   = 8;
    localparam int CFG_IDX_W = 2;

    // decimal printing
    localparam int MAX_DIGITS = 5;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int PROD_W     = 2 * NUM_W;
    // floor(n / 10) == (n * 0xCCCD) >> 19 for every 16-bit n
    localparam logic [NUM_W-1:0] RECIP_10    = 16'hCCCD;
    localparam int               RECIP_SHIFT = 19;
    localparam logic [3:0]       TEN         = 4'd10;

    // display constants
    localparam logic [BYTE_W-1:0] CLEAR_CMD  = 8'h01;
    localparam logic [BYTE_W-1:0] DDRAM_CMD  = 8'h80;
    localparam logic [BYTE_W-1:0] ROW1_BASE  = 8'h40;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

    // register reset values
    localparam logic [BYTE_W-1:0] RST_FUNCTION = 8'd40;
    localparam logic [BYTE_W-1:0] RST_DISPLAY  = 8'd12;
    localparam logic [BYTE_W-1:0] RST_ENTRY    = 8'd6;
    localparam logic [WAIT_W-1:0] RST_PWR_WAIT = 8'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FUNCTION = 2'd0,
        CFG_DISPLAY  = 2'd1,
        CFG_ENTRY    = 2'd2,
        CFG_PWR_WAIT = 2'd3
    } cfg_idx_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INIT   = 3'd0,
        FUNC_CMD    = 3'd1,
        FUNC_DATA   = 3'd2,
        FUNC_CURSOR = 3'd3,
        FUNC_CLEAR  = 3'd4,
        FUNC_PRINT  = 3'd5
    } func_t;

    // microcode
    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_INIT  = 5'd0;
    localparam pc_t PC_CLEAR = 5'd11;
    localparam pc_t PC_CMD   = 5'd13;
    localparam pc_t PC_DATA  = 5'd15;
    localparam pc_t PC_PRINT = 5'd17;
    localparam pc_t PC_DIGIT = 5'd18;
    localparam pc_t PC_LAST  = 5'd19;

    typedef enum logic {
        KIND_EMIT = 1'b0,
        KIND_DIV  = 1'b1
    } step_kind_t;

    typedef enum logic [2:0] {
        SRC_OPND  = 3'd0,
        SRC_FUNC  = 3'd1,
        SRC_DISP  = 3'd2,
        SRC_ENTRY = 3'd3,
        SRC_CLEAR = 3'd4,
        SRC_DIGIT = 3'd5,
        SRC_LIT   = 3'd6
    } byte_src_t;

    typedef enum logic {
        WAIT_LIT = 1'b0,
        WAIT_PWR = 1'b1
    } wait_sel_t;

    typedef enum logic [1:0] {
        SEQ_NEXT       = 2'd0,
        SEQ_END        = 2'd1,
        SEQ_DIV_LOOP   = 2'd2,
        SEQ_DIGIT_LOOP = 2'd3
    } seq_t;

    typedef struct packed {
        step_kind_t       kind;
        logic             strobe;
        logic             rs;
        byte_src_t        src;
        logic             hi;
        logic [NIB_W-1:0] lit_nib;
        wait_sel_t        wsel;
        logic [2:0]       lit_wait;
        seq_t             seq;
        pc_t              target;
    } ctrl_word_t;

    typedef struct packed {
        logic div_more;
        logic print_more;
    } digit_stat_t;

    typedef struct packed {
        logic valid;
        pc_t  pc;
    } entry_t;

    function automatic entry_t entry_of(input logic [FUNC_W-1:0] f);
        entry_t e;
        e.valid = 1'b1;
        e.pc    = PC_INIT;
        case (f)
            FUNC_INIT:   e.pc = PC_INIT;
            FUNC_CMD:    e.pc = PC_CMD;
            FUNC_CURSOR: e.pc = PC_CMD;
            FUNC_DATA:   e.pc = PC_DATA;
            FUNC_CLEAR:  e.pc = PC_CLEAR;
            FUNC_PRINT:  e.pc = PC_PRINT;
            default:     e.valid = 1'b0;
        endcase
        return e;
    endfunction

endpackage

### rtl/lcdseq_req_if.sv
interface lcdseq_req_if import lcdseq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] byte_value;
    logic              row;
    logic [COL_W-1:0]  col;
    logic [NUM_W-1:0]  number;

    modport source (output valid, func, byte_value, row, col, number, input ready);
    modport sink   (input valid, func, byte_value, row, col, number, output ready);
endinterface

### rtl/lcdseq_xfer_if.sv
interface lcdseq_xfer_if import lcdseq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              reg_select;
    logic [NIB_W-1:0]  nibble;
    logic              strobe_res;
    logic [WAIT_W-1:0] wait_after_ms;
    logic              last;

    modport source (output valid, reg_select, nibble, strobe_res, wait_after_ms, last,
                    input ready);
    modport sink   (input valid, reg_select, nibble, strobe_res, wait_after_ms, last,
                    output ready);
endinterface

### rtl/lcdseq_cfg_if.sv
interface lcdseq_cfg_if import lcdseq_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/lcdseq_ucode_rom.sv
module lcdseq_ucode_rom import lcdseq_pkg::*;
(
    input  pc_t        pc,
    output ctrl_word_t word
);

    function automatic ctrl_word_t uw(
        input step_kind_t       kind,
        input logic             strobe,
        input logic             rs,
        input byte_src_t        src,
        input logic             hi,
        input logic [NIB_W-1:0] lit_nib,
        input wait_sel_t        wsel,
        input logic [2:0]       lit_wait,
        input seq_t             seq,
        input pc_t              target
    );
        ctrl_word_t w;
        w.kind     = kind;
        w.strobe   = strobe;
        w.rs       = rs;
        w.src      = src;
        w.hi       = hi;
        w.lit_nib  = lit_nib;
        w.wsel     = wsel;
        w.lit_wait = lit_wait;
        w.seq      = seq;
        w.target   = target;
        return w;
    endfunction

    always_comb
    begin
        case (pc)
            // init: power-up wait, wake-up nibbles, three setup words, clear
            5'd0:  word = uw(KIND_EMIT, 1'b0, 1'b0, SRC_LIT, 1'b0, 4'h0, WAIT_PWR, 3'd0,
                             SEQ_NEXT, PC_INIT);
            5'd1:  word = uw(KIND_EMIT, 1'b1, 1'b0, SRC_LIT, 1'b0, 4'h3, WAIT_LIT, 3'd5,
                             SEQ_NEXT, PC_INIT);
            5'd2:  word = uw(KIND_EMIT, 1'b1, 1'b0, SRC_LIT, 1'b0, 4'h3, WAIT_LIT, 3'd5,
                             SEQ_NEXT, PC_INIT);
            5'd3:  word = uw(KIND_EMIT, 1'b1, 1'b0, SRC_LIT, 1'b0, 4'h3, WAIT_LIT, 3'd1,
                             SEQ_NEXT, PC_INIT);
            5'd4:  word = uw(KIND_EMIT, 1'b1, 1'b0, SRC_LIT, 1'b0, 4'h2, WAIT_LIT, 3'd0,
                             SEQ_NEXT, PC_INIT);
            5'd5:  word = uw(KIND_EMIT, 1'b1, 1'b0, SRC_FUNC, 1'b1, 4'h0, WAIT_LIT, 3'd0,
                             SEQ_NEXT, PC_INIT);
            5'd6:  word = uw(KIND_EMIT, 1'b1, 1'b0, SRC_FUNC, 1'b0, 4'h0, WAIT_LIT, 3'd2,
                             SEQ_NEXT, PC_INIT);
            5'd7:  word = uw(KIND_EMIT, 1'b1, 1'b0, SRC_DISP, 1'b1, 4'h0, WAIT_LIT, 3'd0,
                             SEQ_NEXT, PC_INIT);
            5'd8:  word = uw(KIND_EMIT, 1'b1, 1'b0, SRC_DISP, 1'b0, 4'h0, WAIT_LIT, 3'd2,
                             SEQ_NEXT, PC_INIT);
            5'd9:  word = uw(KIND_EMIT, 1'b1, 1'b0, SRC_ENTRY, 1'b1, 4'h0, WAIT_LIT, 3'd0,
                             SEQ_NEXT, PC_INIT);
            5'd10: word = uw(KIND_EMIT, 1'b1, 1'b0, SRC_ENTRY, 1'b0, 4'h0, WAIT_LIT, 3'd2,
                             SEQ_NEXT, PC_INIT);
            // clear, shared with init
            5'd11: word = uw(KIND_EMIT, 1'b1, 1'b0, SRC_CLEAR, 1'b1, 4'h0, WAIT_LIT, 3'd0,
                             SEQ_NEXT, PC_INIT);
            5'd12: word = uw(KIND_EMIT, 1'b1, 1'b0, SRC_CLEAR, 1'b0, 4'h0, WAIT_LIT, 3'd4,
                             SEQ_END, PC_INIT);
            // command byte or cursor address
            5'd13: word = uw(KIND_EMIT, 1'b1, 1'b0, SRC_OPND, 1'b1, 4'h0, WAIT_LIT, 3'd0,
                             SEQ_NEXT, PC_INIT);
            5'd14: word = uw(KIND_EMIT, 1'b1, 1'b0, SRC_OPND, 1'b0, 4'h0, WAIT_LIT, 3'd2,
                             SEQ_END, PC_INIT);
            // data byte
            5'd15: word = uw(KIND_EMIT, 1'b1, 1'b1, SRC_OPND, 1'b1, 4'h0, WAIT_LIT, 3'd0,
                             SEQ_NEXT, PC_INIT);
            5'd16: word = uw(KIND_EMIT, 1'b1, 1'b1, SRC_OPND, 1'b0, 4'h0, WAIT_LIT, 3'd0,
                             SEQ_END, PC_INIT);
            // decimal: split into digits, then send them top down
            5'd17: word = uw(KIND_DIV, 1'b0, 1'b0, SRC_DIGIT, 1'b0, 4'h0, WAIT_LIT, 3'd0,
                             SEQ_DIV_LOOP, PC_PRINT);
            5'd18: word = uw(KIND_EMIT, 1'b1, 1'b1, SRC_DIGIT, 1'b1, 4'h0, WAIT_LIT, 3'd0,
                             SEQ_NEXT, PC_INIT);
            5'd19: word = uw(KIND_EMIT, 1'b1, 1'b1, SRC_DIGIT, 1'b0, 4'h0, WAIT_LIT, 3'd0,
                             SEQ_DIGIT_LOOP, PC_DIGIT);
            default: word = uw(KIND_EMIT, 1'b0, 1'b0, SRC_LIT, 1'b0, 4'h0, WAIT_LIT, 3'd0,
                               SEQ_END, PC_INIT);
        endcase
    end

endmodule

### rtl/lcdseq_digit_unit.sv
module lcdseq_digit_unit import lcdseq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [NUM_W-1:0]  num_in,
    input  logic              div_step,
    input  logic              pop,
    output digit_stat_t       stat,
    output logic [NIB_W-1:0]  digit
);

    logic [NUM_W-1:0]  num_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NIB_W-1:0]  digits_reg [MAX_DIGITS];

    logic [PROD_W-1:0] prod;
    logic [NUM_W-1:0]  quot;
    logic [NUM_W-1:0]  rem;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  rd_idx;

    // divide by ten via reciprocal multiply
    assign prod    = PROD_W'(num_reg) * PROD_W'(RECIP_10);
    assign quot    = NUM_W'(prod >> RECIP_SHIFT);
    assign rem     = num_reg - NUM_W'(quot * NUM_W'(TEN));
    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign rd_idx  = cnt_reg - CNT_W'(1);

    assign stat.div_more   = (quot != '0) && (cnt_inc < CNT_W'(MAX_DIGITS));
    assign stat.print_more = cnt_reg > CNT_W'(1);
    assign digit           = digits_reg[rd_idx[IDX_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= '0;
        end
        else if (div_step)
        begin
            cnt_reg <= cnt_inc;
        end
        else if (pop)
        begin
            cnt_reg <= rd_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg <= num_in;
        end
        else if (div_step)
        begin
            num_reg                        <= quot;
            digits_reg[cnt_reg[IDX_W-1:0]] <= rem[NIB_W-1:0];
        end
    end

endmodule

### rtl/char_lcd_nibble_sequencer.sv
// Character LCD nibble sequencer for a 4-bit HD44780-style bus. Each accepted
// request (init, command byte, data byte, set cursor, clear, print decimal)
// produces a run of transfers on the xfer channel, each carrying register
// select, the D4..D7 nibble, whether enable is pulsed, and the extra wait in
// ms the display driver must hold after it; last marks the final transfer of
// the request. Func codes 6 and 7 are taken and produce nothing. A short
// microprogram in a ROM drives the datapath, one step per cycle, though a
// transfer step waits while the output register is full and not drained;
// printing a number also spends one divide-by-ten step per decimal digit.
// req is ready whenever no request is in progress, so the next one is taken
// while the previous final transfer still waits in the output register.
// Configuration writes are always taken and should only be done while idle.
module char_lcd_nibble_sequencer import lcdseq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    lcdseq_req_if.sink   req,
    lcdseq_xfer_if.source xfer,
    lcdseq_cfg_if.sink   cfg
);

    // configuration registers
    logic [BYTE_W-1:0] func_word_reg;
    logic [BYTE_W-1:0] disp_word_reg;
    logic [BYTE_W-1:0] entry_word_reg;
    logic [WAIT_W-1:0] pwr_wait_reg;

    // sequencer
    logic              busy_reg;
    logic              busy_next;
    pc_t               pc_reg;
    pc_t               pc_next;
    ctrl_word_t        ctl;

    // operand captured at request transfer
    logic [BYTE_W-1:0] opnd_reg;

    // output register
    logic              xfer_valid_reg;
    logic              rs_reg;
    logic [NIB_W-1:0]  nib_reg;
    logic              strobe_reg;
    logic [WAIT_W-1:0] wait_reg;
    logic              last_reg;

    logic              req_fire;
    entry_t            entry;
    logic              out_free;
    logic              emit_go;
    logic              div_go;
    logic              last_now;
    logic              pop;
    digit_stat_t       dstat;
    logic [NIB_W-1:0]  digit;
    logic [BYTE_W-1:0] src_byte;
    logic [NIB_W-1:0]  nib_sel;
    logic [WAIT_W-1:0] wait_sel;
    logic [BYTE_W-1:0] cursor_byte;

    assign req.ready = !busy_reg;
    assign req_fire  = req.valid && !busy_reg;
    assign entry     = entry_of(req.func);
    assign cfg.ready = 1'b1;

    // row 1 starts at DDRAM address 0x40; col goes through unclamped
    assign cursor_byte = DDRAM_CMD | (req.row ? ROW1_BASE : '0) | BYTE_W'(req.col);

    lcdseq_ucode_rom u_rom
    (
        .pc   (pc_reg),
        .word (ctl)
    );

    // the output register is free when empty or being drained this cycle
    assign out_free = !xfer_valid_reg || xfer.ready;
    assign emit_go  = busy_reg && (ctl.kind == KIND_EMIT) && out_free;
    assign div_go   = busy_reg && (ctl.kind == KIND_DIV);
    assign last_now = (ctl.seq == SEQ_END) ||
                      ((ctl.seq == SEQ_DIGIT_LOOP) && !dstat.print_more);
    assign pop      = emit_go && (ctl.seq == SEQ_DIGIT_LOOP) && dstat.print_more;

    lcdseq_digit_unit u_digit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (req_fire && (req.func == FUNC_PRINT)),
        .num_in   (req.number),
        .div_step (div_go),
        .pop      (pop),
        .stat     (dstat),
        .digit    (digit)
    );

    // byte source and nibble selection
    always_comb
    begin
        case (ctl.src)
            SRC_OPND:  src_byte = opnd_reg;
            SRC_FUNC:  src_byte = func_word_reg;
            SRC_DISP:  src_byte = disp_word_reg;
            SRC_ENTRY: src_byte = entry_word_reg;
            SRC_CLEAR: src_byte = CLEAR_CMD;
            SRC_DIGIT: src_byte = ASCII_ZERO | BYTE_W'(digit);
            default:   src_byte = '0;
        endcase

        if (ctl.src == SRC_LIT)
        begin
            nib_sel = ctl.lit_nib;
        end
        else if (ctl.hi)
        begin
            nib_sel = src_byte[BYTE_W-1:NIB_W];
        end
        else
        begin
            nib_sel = src_byte[NIB_W-1:0];
        end

        wait_sel = (ctl.wsel == WAIT_PWR) ? pwr_wait_reg : WAIT_W'(ctl.lit_wait);
    end

    // step counter and jumps
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (req_fire)
        begin
            busy_next = entry.valid;
            pc_next   = entry.pc;
        end
        else if (emit_go || div_go)
        begin
            case (ctl.seq)
                SEQ_NEXT:
                begin
                    pc_next = pc_reg + PC_W'(1);
                end
                SEQ_END:
                begin
                    busy_next = 1'b0;
                end
                SEQ_DIV_LOOP:
                begin
                    pc_next = dstat.div_more ? ctl.target : pc_reg + PC_W'(1);
                end
                SEQ_DIGIT_LOOP:
                begin
                    if (dstat.print_more)
                    begin
                        pc_next = ctl.target;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= PC_INIT;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            opnd_reg <= (req.func == FUNC_CURSOR) ? cursor_byte : req.byte_value;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_word_reg  <= RST_FUNCTION;
            disp_word_reg  <= RST_DISPLAY;
            entry_word_reg <= RST_ENTRY;
            pwr_wait_reg   <= RST_PWR_WAIT;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FUNCTION: func_word_reg  <= cfg.data;
                CFG_DISPLAY:  disp_word_reg  <= cfg.data;
                CFG_ENTRY:    entry_word_reg <= cfg.data;
                CFG_PWR_WAIT: pwr_wait_reg   <= cfg.data;
                default:      func_word_reg  <= func_word_reg;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xfer_valid_reg <= 1'b0;
        end
        else if (emit_go)
        begin
            xfer_valid_reg <= 1'b1;
        end
        else if (xfer.ready)
        begin
            xfer_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            rs_reg     <= ctl.rs;
            nib_reg    <= nib_sel;
            strobe_reg <= ctl.strobe;
            wait_reg   <= wait_sel;
            last_reg   <= last_now;
        end
    end

    assign xfer.valid         = xfer_valid_reg;
    assign xfer.reg_select    = rs_reg;
    assign xfer.nibble        = nib_reg;
    assign xfer.strobe_res    = strobe_reg;
    assign xfer.wait_after_ms = wait_reg;
    assign xfer.last          = last_reg;

    // the final transfer of a request ends the program
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && last_now) |=> !busy_reg)
        else $error("sequencer still busy after final transfer");

    // a known request starts the program
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && entry.valid) |=> busy_reg)
        else $error("request transfer did not start the sequencer");

    // step counter stays inside the program
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= PC_LAST))
        else $error("step counter outside microprogram");

    // an issued step lands in the output register
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> xfer_valid_reg)
        else $error("issued transfer not held in output register");

endmodule

### bench/tb_top.sv
module tb_top;
    import lcdseq_pkg::*;

    // func codes the block takes but turns into no transfers
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    // run limits
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_PAUSE    = 18;

    // one request as the sender presents it
    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] byte_value;
        logic              row;
        logic [COL_W-1:0]  col;
        logic [NUM_W-1:0]  number;
    } lcd_req_t;

    // one nibble transfer toward the display
    typedef struct {
        logic              reg_select;
        logic [NIB_W-1:0]  nibble;
        logic              strobe_res;
        logic [WAIT_W-1:0] wait_after_ms;
        logic              last;
    } lcd_xfer_t;

    logic clk;
    logic rst_n;

    lcdseq_req_if  req_ch ();
    lcdseq_xfer_if xfer_ch ();
    lcdseq_cfg_if  cfg_ch ();

    char_lcd_nibble_sequencer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .xfer  (xfer_ch),
        .cfg   (cfg_ch)
    );

    // shadow copy of the init words and power-up wait
    logic [BYTE_W-1:0] shadow_function;
    logic [BYTE_W-1:0] shadow_display;
    logic [BYTE_W-1:0] shadow_entry;
    logic [WAIT_W-1:0] shadow_pwr_wait;

    lcd_req_t  pending_reqs[$];     // requests not yet handed to the driver
    lcd_xfer_t expected_xfers[$];   // transfers the block still owes
    lcd_req_t  cur_req;

    int  gap_left;
    int  stall_left;
    bit  sender_idles;
    bit  receiver_idles;
    int  mismatch_count;
    int  req_count;
    int  xfer_count;
    int  cfg_count;
    int  cycle_count;

    // clock, 10 time units per period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog on total run length
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d transfers still outstanding", $time,
                     expected_xfers.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // pause length per transfer: mostly none or short, sometimes the full range
    function automatic int draw_pause(input bit enabled);
        int pick;
        pick = $urandom_range(0, 3);
        if (!enabled)
            return 0;
        case (pick)
            0, 1:    return 0;
            2:       return $urandom_range(1, 4);
            default: return $urandom_range(0, MAX_PAUSE);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // transfer prediction
    // ------------------------------------------------------------------
    task automatic push_xfer(input logic rs, input logic [NIB_W-1:0] nib,
                             input logic strobe, input logic [WAIT_W-1:0] wt);
        lcd_xfer_t x;
        x.reg_select    = rs;
        x.nibble        = nib;
        x.strobe_res    = strobe;
        x.wait_after_ms = wt;
        x.last          = 1'b0;
        expected_xfers.push_back(x);
    endtask

    // a byte leaves as two strobed nibbles, high first, wait on the low one
    task automatic push_byte(input logic rs, input logic [BYTE_W-1:0] b,
                             input logic [WAIT_W-1:0] wt);
        push_xfer(rs, b[7:4], 1'b1, '0);
        push_xfer(rs, b[3:0], 1'b1, wt);
    endtask

    task automatic predict_transfers(input lcd_req_t r);
        int                unsigned value;
        logic [3:0]        digits[MAX_DIGITS];
        int                ndig;
        int                i;
        int                before_count;
        logic [BYTE_W-1:0] addr;
        lcd_xfer_t         tail;
        before_count = expected_xfers.size();
        case (r.func)
            FUNC_INIT:
            begin
                // wait-only transfer for power-up, then the 4-bit wake-up nibbles
                push_xfer(1'b0, 4'h0, 1'b0, shadow_pwr_wait);
                push_xfer(1'b0, 4'h3, 1'b1, 8'd5);
                push_xfer(1'b0, 4'h3, 1'b1, 8'd5);
                push_xfer(1'b0, 4'h3, 1'b1, 8'd1);
                push_xfer(1'b0, 4'h2, 1'b1, 8'd0);
                push_byte(1'b0, shadow_function, 8'd2);
                push_byte(1'b0, shadow_display, 8'd2);
                push_byte(1'b0, shadow_entry, 8'd2);
                push_byte(1'b0, CLEAR_CMD, 8'd4);
            end
            FUNC_CMD:
                push_byte(1'b0, r.byte_value, 8'd2);
            FUNC_DATA:
                push_byte(1'b1, r.byte_value, 8'd0);
            FUNC_CURSOR:
            begin
                // no clamping of col, second line is offset by 0x40
                addr = r.row ? (ROW1_BASE + BYTE_W'(r.col)) : BYTE_W'(r.col);
                push_byte(1'b0, DDRAM_CMD | addr, 8'd2);
            end
            FUNC_CLEAR:
                push_byte(1'b0, CLEAR_CMD, 8'd4);
            FUNC_PRINT:
            begin
                value = 32'(r.number);
                ndig  = 0;
                if (value == 0)
                    push_byte(1'b1, ASCII_ZERO, 8'd0);
                else
                begin
                    // only the lowest digits survive when the number is too long
                    while (value > 0 && ndig < MAX_DIGITS)
                    begin
                        digits[ndig] = 4'(value % 10);
                        value        = value / 10;
                        ndig++;
                    end
                    for (i = ndig - 1; i >= 0; i--)
                        push_byte(1'b1, ASCII_ZERO + BYTE_W'(digits[i]), 8'd0);
                end
            end
            default:
            begin
                // spare codes are swallowed without output
            end
        endcase
        if (expected_xfers.size() > before_count)
        begin
            tail      = expected_xfers.pop_back();
            tail.last = 1'b1;
            expected_xfers.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------
    // request driver: feeds pending_reqs into the req channel
    // ------------------------------------------------------------------
    task automatic present_req(input lcd_req_t r);
        req_ch.func       <= r.func;
        req_ch.byte_value <= r.byte_value;
        req_ch.row        <= r.row;
        req_ch.col        <= r.col;
        req_ch.number     <= r.number;
        req_ch.valid      <= 1'b1;
    endtask

    always @(posedge clk)
    begin
        int pause;
        if (rst_n)
        begin
            if (req_ch.valid)
            begin
                if (req_ch.ready)
                begin
                    // request transfer: expectations are fixed by the shadow config now
                    predict_transfers(cur_req);
                    req_count <= req_count + 1;
                    pause = draw_pause(sender_idles);
                    if (pause == 0 && pending_reqs.size() > 0)
                    begin
                        // back to back, valid stays high
                        cur_req = pending_reqs.pop_front();
                        present_req(cur_req);
                    end
                    else
                    begin
                        req_ch.valid <= 1'b0;
                        gap_left     <= (pause > 0) ? pause - 1 : 0;
                    end
                end
            end
            else if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_reqs.size() > 0)
            begin
                cur_req = pending_reqs.pop_front();
                present_req(cur_req);
            end
        end
    end

    // ------------------------------------------------------------------
    // transfer monitor: stalls ready at random and checks each transfer
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: transfer %0d %s expected 0x%h actual 0x%h", $time,
                     xfer_count, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        lcd_xfer_t want;
        int        pause;
        if (rst_n)
        begin
            if (xfer_ch.valid && xfer_ch.ready)
            begin
                if (expected_xfers.size() == 0)
                begin
                    $display("%0t: unexpected transfer expected none actual rs=%b nib=%h", $time,
                             xfer_ch.reg_select, xfer_ch.nibble);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_xfers.pop_front();
                    check_field("reg_select", 8'(want.reg_select), 8'(xfer_ch.reg_select));
                    check_field("nibble", 8'(want.nibble), 8'(xfer_ch.nibble));
                    check_field("strobe_res", 8'(want.strobe_res), 8'(xfer_ch.strobe_res));
                    check_field("wait_after_ms", want.wait_after_ms, xfer_ch.wait_after_ms);
                    check_field("last", 8'(want.last), 8'(xfer_ch.last));
                end
                xfer_count <= xfer_count + 1;
                pause = draw_pause(receiver_idles);
                if (pause > 0)
                begin
                    xfer_ch.ready <= 1'b0;
                    stall_left    <= pause - 1;
                end
            end
            else if (!xfer_ch.ready)
            begin
                if (stall_left == 0)
                    xfer_ch.ready <= 1'b1;
                else
                    stall_left <= stall_left - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic lcd_req_t make_req(input logic [FUNC_W-1:0] f,
                                          input logic [BYTE_W-1:0] b, input logic r,
                                          input logic [COL_W-1:0] c,
                                          input logic [NUM_W-1:0] n);
        lcd_req_t q;
        q.func       = f;
        q.byte_value = b;
        q.row        = r;
        q.col        = c;
        q.number     = n;
        return q;
    endfunction

    // random request, unused fields still random so every bit toggles
    function automatic lcd_req_t random_req();
        lcd_req_t q;
        int       pick;
        int       len;
        pick         = $urandom_range(0, 99);
        q.byte_value = BYTE_W'($urandom);
        q.row        = 1'($urandom);
        q.col        = ($urandom_range(0, 7) == 0) ? COL_W'($urandom_range(40, 63))
                                                   : COL_W'($urandom_range(0, 39));
        len = $urandom_range(0, 5);
        case (len)
            0:       q.number = NUM_W'($urandom);
            1:       q.number = NUM_W'($urandom_range(0, 9));
            2:       q.number = NUM_W'($urandom_range(10, 99));
            3:       q.number = NUM_W'($urandom_range(100, 999));
            4:       q.number = NUM_W'($urandom_range(1000, 9999));
            default: q.number = NUM_W'($urandom_range(10000, 65535));
        endcase
        if (pick < 6)
            q.func = FUNC_INIT;
        else if (pick < 20)
            q.func = FUNC_CMD;
        else if (pick < 38)
            q.func = FUNC_DATA;
        else if (pick < 54)
            q.func = FUNC_CURSOR;
        else if (pick < 64)
            q.func = FUNC_CLEAR;
        else if (pick < 94)
            q.func = FUNC_PRINT;
        else
            q.func = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
        return q;
    endfunction

    // one register write, valid is dropped between writes
    task automatic write_reg(input cfg_idx_t idx, input logic [BYTE_W-1:0] value);
        @(posedge clk);
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        // write transfer at this edge
        case (idx)
            CFG_FUNCTION: shadow_function = value;
            CFG_DISPLAY:  shadow_display  = value;
            CFG_ENTRY:    shadow_entry    = value;
            CFG_PWR_WAIT: shadow_pwr_wait = value;
            default:      ;
        endcase
        cfg_count++;
        cfg_ch.valid <= 1'b0;
    endtask

    // block until the sender is empty and every transfer has come back
    task automatic settle();
        @(negedge clk);
        while (pending_reqs.size() > 0 || req_ch.valid || expected_xfers.size() > 0)
            @(negedge clk);
        // spare codes leave nothing to wait on, give the sequencer time to finish
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int phase;
        int k;
        int mode;

        // known levels on every input before the first edge
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.func        = FUNC_INIT;
        req_ch.byte_value  = '0;
        req_ch.row         = 1'b0;
        req_ch.col         = '0;
        req_ch.number      = '0;
        xfer_ch.ready      = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_FUNCTION;
        cfg_ch.data        = '0;
        gap_left           = 0;
        stall_left         = 0;
        sender_idles       = 1'b1;
        receiver_idles     = 1'b1;
        mismatch_count     = 0;
        req_count          = 0;
        xfer_count         = 0;
        cfg_count          = 0;
        shadow_function    = RST_FUNCTION;
        shadow_display     = RST_DISPLAY;
        shadow_entry       = RST_ENTRY;
        shadow_pwr_wait    = RST_PWR_WAIT;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on reset config values
        @(negedge clk);
        pending_reqs.push_back(make_req(FUNC_INIT, 8'h00, 1'b0, 6'd0, 16'd0));
        pending_reqs.push_back(make_req(FUNC_CMD, 8'h00, 1'b1, 6'd63, 16'hFFFF));
        pending_reqs.push_back(make_req(FUNC_CMD, 8'hFF, 1'b0, 6'd0, 16'h0000));
        pending_reqs.push_back(make_req(FUNC_DATA, 8'h00, 1'b0, 6'd0, 16'd0));
        pending_reqs.push_back(make_req(FUNC_DATA, 8'hFF, 1'b1, 6'd21, 16'hAAAA));
        pending_reqs.push_back(make_req(FUNC_DATA, 8'hA5, 1'b0, 6'd42, 16'h5555));
        // cursor corners, including columns past the visible line
        pending_reqs.push_back(make_req(FUNC_CURSOR, 8'h00, 1'b0, 6'd0, 16'd0));
        pending_reqs.push_back(make_req(FUNC_CURSOR, 8'h00, 1'b0, 6'd39, 16'd0));
        pending_reqs.push_back(make_req(FUNC_CURSOR, 8'h00, 1'b1, 6'd0, 16'd0));
        pending_reqs.push_back(make_req(FUNC_CURSOR, 8'h00, 1'b1, 6'd39, 16'd0));
        pending_reqs.push_back(make_req(FUNC_CURSOR, 8'h00, 1'b0, 6'd63, 16'd0));
        pending_reqs.push_back(make_req(FUNC_CURSOR, 8'h00, 1'b1, 6'd63, 16'd0));
        pending_reqs.push_back(make_req(FUNC_CLEAR, 8'h5A, 1'b1, 6'd17, 16'd77));
        // decimal: zero, single digit, digit boundaries, zeros inside, the maximum
        pending_reqs.push_back(make_req(FUNC_PRINT, 8'h00, 1'b0, 6'd0, 16'd0));
        pending_reqs.push_back(make_req(FUNC_PRINT, 8'h00, 1'b0, 6'd0, 16'd9));
        pending_reqs.push_back(make_req(FUNC_PRINT, 8'h00, 1'b0, 6'd0, 16'd10));
        pending_reqs.push_back(make_req(FUNC_PRINT, 8'h00, 1'b0, 6'd0, 16'd1000));
        pending_reqs.push_back(make_req(FUNC_PRINT, 8'h00, 1'b0, 6'd0, 16'd10000));
        pending_reqs.push_back(make_req(FUNC_PRINT, 8'h00, 1'b0, 6'd0, 16'd12345));
        pending_reqs.push_back(make_req(FUNC_PRINT, 8'h00, 1'b0, 6'd0, 16'd65535));
        // spare selectors between real requests
        pending_reqs.push_back(make_req(FUNC_SPARE_LO, 8'hFF, 1'b1, 6'd63, 16'hFFFF));
        pending_reqs.push_back(make_req(FUNC_DATA, 8'h3C, 1'b0, 6'd5, 16'd5));
        pending_reqs.push_back(make_req(FUNC_SPARE_HI, 8'h00, 1'b0, 6'd0, 16'd0));
        pending_reqs.push_back(make_req(FUNC_INIT, 8'hC3, 1'b1, 6'd33, 16'd4321));
        settle();

        // config phases: all zeros, all ones, then random words
        for (phase = 0; phase < 7; phase++)
        begin
            if (phase == 0)
            begin
                write_reg(CFG_FUNCTION, 8'h00);
                write_reg(CFG_DISPLAY, 8'h00);
                write_reg(CFG_ENTRY, 8'h00);
                write_reg(CFG_PWR_WAIT, 8'h00);
            end
            else if (phase == 1)
            begin
                write_reg(CFG_FUNCTION, 8'hFF);
                write_reg(CFG_DISPLAY, 8'hFF);
                write_reg(CFG_ENTRY, 8'hFF);
                write_reg(CFG_PWR_WAIT, 8'hFF);
            end
            else
            begin
                write_reg(CFG_PWR_WAIT, BYTE_W'($urandom));
                write_reg(CFG_ENTRY, BYTE_W'($urandom));
                write_reg(CFG_FUNCTION, BYTE_W'($urandom));
                write_reg(CFG_DISPLAY, BYTE_W'($urandom));
            end

            // idle pattern for this phase, one phase fully back to back
            mode = (phase == 3) ? 0 : $urandom_range(0, 3);
            @(negedge clk);
            sender_idles   = (mode == 1 || mode == 3);
            receiver_idles = (mode == 2 || mode == 3) || (mode == 1 && phase != 4);

            // init first so the new words are exercised
            pending_reqs.push_back(make_req(FUNC_INIT, BYTE_W'($urandom), 1'($urandom),
                                            COL_W'($urandom), NUM_W'($urandom)));
            for (k = 0; k < ((phase < 2) ? 12 : 13); k++)
                pending_reqs.push_back(random_req());
            settle();
        end

        $display("covered %0d requests, %0d nibble transfers, %0d register writes",
                 req_count, xfer_count, cfg_count);
        $display("over reset, all-zero, all-one and random init words with random stalls");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
